// ===== hdl/lpmd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmd_pkg
// Types and constants shared by the length-prefixed message deframer.
// ----------------------------------------------------------------------------
package lpmd_pkg;

  localparam int unsigned MAGIC_W = 32;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned TYPE_W  = 32;
  localparam int unsigned SIZE_W  = 31;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 3;

  // last byte index of each header field
  localparam logic [CNT_W-1:0] LAST_IDX_WORD = 3'd3;
  localparam logic [CNT_W-1:0] LAST_IDX_TIME = 3'd7;

  typedef enum logic [2:0] {
    PH_MAGIC = 3'd0,
    PH_TIME  = 3'd1,
    PH_TYPE  = 3'd2,
    PH_SIZE  = 3'd3,
    PH_BODY  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BODY      = 2'd0,
    KIND_BAD_MAGIC = 2'd1,
    KIND_EMPTY     = 2'd2
  } kind_t;

  typedef struct packed {
    logic                     valid;
    kind_t                    kind;
    logic [BYTE_W-1:0]        body_byte;
    logic                     end_of_message;
    logic signed [TIME_W-1:0] msg_time;
    logic signed [TYPE_W-1:0] msg_type;
    logic [SIZE_W-1:0]        msg_size;
  } result_t;

endpackage

// ===== hdl/lpmd_if.sv =====
// ----------------------------------------------------------------------------
// lpmd_if
// Valid/ready channels of the deframer: byte input, result output, config.
// ----------------------------------------------------------------------------
interface lpmd_byte_if import lpmd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface lpmd_msg_if import lpmd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  kind_t                    kind;
  logic [BYTE_W-1:0]        body_byte;
  logic                     end_of_message;
  logic signed [TIME_W-1:0] msg_time;
  logic signed [TYPE_W-1:0] msg_type;
  logic [SIZE_W-1:0]        msg_size;

  modport source (output valid, output kind, output body_byte, output end_of_message,
                  output msg_time, output msg_type, output msg_size, input ready);
  modport sink   (input valid, input kind, input body_byte, input end_of_message,
                  input msg_time, input msg_type, input msg_size, output ready);
endinterface

interface lpmd_cfg_if import lpmd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MAGIC_W-1:0] expected_magic;

  modport source (output valid, output expected_magic, input ready);
  modport sink   (input valid, input expected_magic, output ready);
endinterface

// ===== hdl/lpmd_parser.sv =====
// ----------------------------------------------------------------------------
// lpmd_parser
// Header/body parse state. One byte per take; result computed combinationally.
// ----------------------------------------------------------------------------
module lpmd_parser import lpmd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [BYTE_W-1:0]  byte_in,
  input  logic [MAGIC_W-1:0] expected_magic,
  output result_t            result
);

  phase_t              phase, phase_next;
  logic [CNT_W-1:0]    field_byte_count, field_byte_count_next;
  logic [TIME_W-1:0]   field_shift, field_shift_next;
  logic [TIME_W-1:0]   held_time, held_time_next;
  logic [TYPE_W-1:0]   held_type, held_type_next;
  logic [SIZE_W-1:0]   held_size, held_size_next;
  logic [SIZE_W-1:0]   body_remaining, body_remaining_next;

  logic [TIME_W-1:0]   shifted;
  logic [TYPE_W-1:0]   word;
  logic [SIZE_W-1:0]   remaining_dec;
  logic                word_done;
  logic                size_empty;

  assign shifted       = {field_shift[TIME_W-BYTE_W-1:0], byte_in};
  assign word          = shifted[TYPE_W-1:0];
  assign word_done     = (field_byte_count == LAST_IDX_WORD);
  assign remaining_dec = body_remaining - SIZE_W'(1);
  // zero or negative length gives an empty message
  assign size_empty    = (word == '0) || word[TYPE_W-1];

  // next state
  always_comb begin
    phase_next            = phase;
    field_byte_count_next = field_byte_count + CNT_W'(1);
    field_shift_next      = shifted;
    held_time_next        = held_time;
    held_type_next        = held_type;
    held_size_next        = held_size;
    body_remaining_next   = body_remaining;
    case (phase)
      PH_TIME: begin
        if (field_byte_count == LAST_IDX_TIME) begin
          field_byte_count_next = '0;
          held_time_next        = shifted;
          phase_next            = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (word_done) begin
          field_byte_count_next = '0;
          held_type_next        = word;
          phase_next            = PH_SIZE;
        end
      end
      PH_SIZE: begin
        if (word_done) begin
          field_byte_count_next = '0;
          if (size_empty) begin
            held_size_next      = '0;
            body_remaining_next = '0;
            phase_next          = PH_MAGIC;
          end else begin
            held_size_next      = word[SIZE_W-1:0];
            body_remaining_next = word[SIZE_W-1:0];
            phase_next          = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        field_shift_next      = field_shift;
        field_byte_count_next = field_byte_count;
        body_remaining_next   = remaining_dec;
        if (remaining_dec == '0) begin
          phase_next            = PH_MAGIC;
          field_byte_count_next = '0;
        end
      end
      default: begin
        // magic word; a mismatch just starts a fresh magic word
        if (word_done) begin
          field_byte_count_next = '0;
          if (word == expected_magic) begin
            phase_next = PH_TIME;
          end
        end
      end
    endcase
  end

  // result
  always_comb begin
    result = '0;
    result.kind = KIND_BODY;
    case (phase)
      PH_SIZE: begin
        if (word_done && size_empty) begin
          result.valid          = 1'b1;
          result.kind           = KIND_EMPTY;
          result.end_of_message = 1'b1;
          result.msg_time       = held_time;
          result.msg_type       = held_type;
        end
      end
      PH_BODY: begin
        result.valid          = 1'b1;
        result.kind           = KIND_BODY;
        result.body_byte      = byte_in;
        result.end_of_message = (remaining_dec == '0);
        result.msg_time       = held_time;
        result.msg_type       = held_type;
        result.msg_size       = held_size;
      end
      PH_MAGIC: begin
        if (word_done && (word != expected_magic)) begin
          result.valid = 1'b1;
          result.kind  = KIND_BAD_MAGIC;
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_MAGIC;
      field_byte_count <= '0;
      field_shift      <= '0;
      held_time        <= '0;
      held_type        <= '0;
      held_size        <= '0;
      body_remaining   <= '0;
    end else if (take) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      field_shift      <= field_shift_next;
      held_time        <= held_time_next;
      held_type        <= held_type_next;
      held_size        <= held_size_next;
      body_remaining   <= body_remaining_next;
    end
  end

endmodule

// ===== hdl/length_prefixed_message_deframer_core.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer_core
// A result word is written to the output register in the cycle after its byte is taken.
// Throughput: 1 byte per cycle; the input stalls only while a result word
//   sits in the output register and the sink is not taking it.
// Reset (rst, synchronous): parser to magic word phase, counts and held
//   header cleared, output register empty, expected_magic = 0.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer_core import lpmd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  lpmd_byte_if.sink    byte_stream,
  lpmd_msg_if.source   msg_stream,
  lpmd_cfg_if.sink     cfg
);

  logic [MAGIC_W-1:0] expected_magic;
  logic               take;
  result_t            result;
  result_t            out_word;
  logic               out_valid, out_valid_next;

  assign cfg.ready         = 1'b1;
  assign byte_stream.ready = !out_valid || msg_stream.ready;
  assign take              = byte_stream.valid && byte_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic <= '0;
    end else if (cfg.valid) begin
      expected_magic <= cfg.expected_magic;
    end
  end

  lpmd_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .byte_in        (byte_stream.byte_in),
    .expected_magic (expected_magic),
    .result         (result)
  );

  always_comb begin
    out_valid_next = out_valid;
    if (take && result.valid) begin
      out_valid_next = 1'b1;
    end else if (msg_stream.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && result.valid) begin
      out_word <= result;
    end
  end

  assign msg_stream.valid          = out_valid;
  assign msg_stream.kind           = out_word.kind;
  assign msg_stream.body_byte      = out_word.body_byte;
  assign msg_stream.end_of_message = out_word.end_of_message;
  assign msg_stream.msg_time       = out_word.msg_time;
  assign msg_stream.msg_type       = out_word.msg_type;
  assign msg_stream.msg_size       = out_word.msg_size;

endmodule

// ===== hdl/lpmd_checker.sv =====
// ----------------------------------------------------------------------------
// lpmd_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module lpmd_checker import lpmd_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input kind_t                    kind,
  input logic [BYTE_W-1:0]        body_byte,
  input logic                     end_of_message,
  input logic signed [TIME_W-1:0] msg_time,
  input logic signed [TYPE_W-1:0] msg_type,
  input logic [SIZE_W-1:0]        msg_size
);

  // a pending word is never dropped
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // input is open whenever the output register is free
  a_in_open: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output register");

  a_bad_magic: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_BAD_MAGIC |-> !end_of_message && body_byte == '0 &&
      msg_time == '0 && msg_type == '0 && msg_size == '0)
    else $error("bad magic word carries metadata");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_EMPTY |-> end_of_message && msg_size == '0 &&
      body_byte == '0)
    else $error("empty message word malformed");

endmodule

bind length_prefixed_message_deframer_core lpmd_checker u_lpmd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (byte_stream.ready),
  .out_valid      (msg_stream.valid),
  .out_ready      (msg_stream.ready),
  .kind           (msg_stream.kind),
  .body_byte      (msg_stream.body_byte),
  .end_of_message (msg_stream.end_of_message),
  .msg_time       (msg_stream.msg_time),
  .msg_type       (msg_stream.msg_type),
  .msg_size       (msg_stream.msg_size)
);

// ===== tb/length_prefixed_message_deframer_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer_core_test
// Feeds framed byte streams (good headers, wrong magic words, empty and
// negative lengths, short and longer bodies) through the deframer with random
// gaps on both channels. Every accepted byte runs through a local parser
// model that queues the expected output words, and each word taken from the
// block is checked against the oldest one. The magic register is rewritten
// between phases, and also while a header is half parsed.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer_core_test;
  import lpmd_pkg::*;

  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_BYTES = 150;
  localparam logic [2:0] WORD_BYTES = 3'd4;
  localparam logic [2:0] TIME_LAST  = 3'd7;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         body_byte;
    logic               end_of_message;
    logic signed [63:0] msg_time;
    logic signed [31:0] msg_type;
    logic [30:0]        msg_size;
  } msg_word_t;

  // how a directed row is checked: by the parser model or by a fixed word
  typedef enum logic [1:0] {CHK_MODEL, CHK_BAD_MAGIC, CHK_EMPTY} chk_t;

  typedef struct {
    bit          set_cfg;
    logic [31:0] cfg_val;
    bit          send_magic;
    bit          send_rest;
    logic [31:0] magic;
    logic [63:0] t;
    logic [31:0] ty;
    logic [31:0] len;
    chk_t        chk;
  } frame_row_t;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    msg_word_t  want;
  } rx_byte_t;

  logic clk;
  logic rst;

  lpmd_byte_if byte_if ();
  lpmd_msg_if  msg_if ();
  lpmd_cfg_if  cfg_if ();

  length_prefixed_message_deframer_core dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_if),
    .msg_stream  (msg_if),
    .cfg         (cfg_if)
  );

  rx_byte_t  rx_bytes[$];
  msg_word_t due_msg_words[$];
  int        errors = 0;
  int        bytes_made = 0;
  bit        steady = 1'b0;
  bit        long_hold_req = 1'b0;

  // parser model state
  logic [31:0] magic_copy = '0;
  phase_t      ph = PH_MAGIC;
  logic [2:0]  fcnt = '0;
  logic [63:0] fshift = '0;
  logic [63:0] hold_time = '0;
  logic [31:0] hold_type = '0;
  logic [30:0] hold_size = '0;
  logic [30:0] body_left = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advances the parser model by one byte; returns 1 when a word comes out.
  function automatic bit deframe_byte(input logic [7:0] b, output msg_word_t w);
    logic [31:0] field;
    w = '0;
    case (ph)
      PH_TIME: begin
        fshift = {fshift[55:0], b};
        if (fcnt == TIME_LAST) begin
          fcnt = '0;
          hold_time = fshift;
          ph = PH_TYPE;
        end else begin
          fcnt = fcnt + 3'd1;
        end
      end
      PH_TYPE: begin
        fshift = {fshift[55:0], b};
        fcnt = fcnt + 3'd1;
        if (fcnt == WORD_BYTES) begin
          fcnt = '0;
          hold_type = fshift[31:0];
          ph = PH_SIZE;
        end
      end
      PH_SIZE: begin
        fshift = {fshift[55:0], b};
        fcnt = fcnt + 3'd1;
        if (fcnt == WORD_BYTES) begin
          fcnt = '0;
          field = fshift[31:0];
          if (field == '0 || field[31]) begin
            hold_size = '0;
            body_left = '0;
            ph = PH_MAGIC;
            w.kind = KIND_EMPTY;
            w.end_of_message = 1'b1;
            w.msg_time = hold_time;
            w.msg_type = hold_type;
            return 1'b1;
          end
          hold_size = field[30:0];
          body_left = field[30:0];
          ph = PH_BODY;
        end
      end
      PH_BODY: begin
        body_left = body_left - 31'd1;
        if (body_left == '0) begin
          ph = PH_MAGIC;
          fcnt = '0;
        end
        w.kind = KIND_BODY;
        w.body_byte = b;
        w.end_of_message = (body_left == '0);
        w.msg_time = hold_time;
        w.msg_type = hold_type;
        w.msg_size = hold_size;
        return 1'b1;
      end
      default: begin
        if (ph != PH_MAGIC) begin
          ph = PH_MAGIC;
          fcnt = '0;
        end
        fshift = {fshift[55:0], b};
        fcnt = fcnt + 3'd1;
        if (fcnt == WORD_BYTES) begin
          fcnt = '0;
          if (fshift[31:0] != magic_copy) begin
            w.kind = KIND_BAD_MAGIC;
            return 1'b1;
          end
          ph = PH_TIME;
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic frame_row_t mk_row(input bit set_cfg, input logic [31:0] cfg_val,
                                        input bit send_magic, input bit send_rest,
                                        input logic [31:0] magic, input logic [63:0] t,
                                        input logic [31:0] ty, input logic [31:0] len,
                                        input chk_t chk);
    frame_row_t r;
    r.set_cfg = set_cfg;
    r.cfg_val = cfg_val;
    r.send_magic = send_magic;
    r.send_rest = send_rest;
    r.magic = magic;
    r.t = t;
    r.ty = ty;
    r.len = len;
    r.chk = chk;
    return r;
  endfunction

  function automatic frame_row_t random_row(input logic [31:0] good);
    frame_row_t r;
    int sel;
    logic [31:0] flip;
    sel = $urandom_range(99);
    flip = $urandom;
    if (flip == '0) flip = 32'h1;
    r = mk_row(1'b0, '0, 1'b1, 1'b1, good, {$urandom, $urandom}, $urandom,
               32'($urandom_range(1, 16)), CHK_MODEL);
    if (sel < 12) begin
      r.magic = good ^ flip;
      r.send_rest = 1'b0;
    end else if (sel < 20) begin
      r.len = $urandom_range(1) ? 32'h0 : {1'b1, 31'($urandom)};
    end else if (sel < 25) begin
      r.len = 32'($urandom_range(33, 96));
    end
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit typed, input msg_word_t want);
    rx_byte_t e;
    e.b = b;
    e.typed = typed;
    e.want = want;
    rx_bytes.push_back(e);
    bytes_made++;
  endtask

  task automatic queue_frame(input frame_row_t r);
    msg_word_t want;
    int nbody;
    want = '0;
    if (r.chk == CHK_BAD_MAGIC) want.kind = KIND_BAD_MAGIC;
    if (r.chk == CHK_EMPTY) begin
      want.kind = KIND_EMPTY;
      want.end_of_message = 1'b1;
      want.msg_time = r.t;
      want.msg_type = r.ty;
    end
    nbody = (r.len == '0 || r.len[31]) ? 0 : int'(r.len);
    if (r.send_magic)
      for (int i = 3; i >= 0; i--)
        push_byte(r.magic[8*i +: 8], r.chk == CHK_BAD_MAGIC && i == 0, want);
    if (r.send_rest) begin
      for (int i = 7; i >= 0; i--) push_byte(r.t[8*i +: 8], 1'b0, want);
      for (int i = 3; i >= 0; i--) push_byte(r.ty[8*i +: 8], 1'b0, want);
      for (int i = 3; i >= 0; i--)
        push_byte(r.len[8*i +: 8], r.chk == CHK_EMPTY && i == 0, want);
      repeat (nbody) push_byte(8'($urandom), 1'b0, want);
    end
  endtask

  // nothing queued, nothing in flight, no words still due
  task automatic wait_idle();
    while (rx_bytes.size() != 0 || byte_if.valid || due_msg_words.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_magic(input logic [31:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.expected_magic <= v;
    do @(posedge clk); while (!cfg_if.ready);
    magic_copy = v;
    cfg_if.valid <= 1'b0;
  endtask

  // byte source; the parser model runs on each accepted byte
  initial begin : byte_sender
    int gap;
    bit got;
    msg_word_t w;
    gap = 0;
    byte_if.valid <= 1'b0;
    byte_if.byte_in <= '0;
    forever begin
      @(posedge clk);
      if (!rst && byte_if.valid && byte_if.ready) begin
        got = deframe_byte(rx_bytes[0].b, w);
        if (rx_bytes[0].typed) due_msg_words.push_back(rx_bytes[0].want);
        else if (got) due_msg_words.push_back(w);
        void'(rx_bytes.pop_front());
        gap = steady ? 0 : pick_gap();
      end else if (!byte_if.valid && gap > 0) begin
        gap--;
      end
      if (!rst && gap == 0 && rx_bytes.size() != 0) begin
        byte_if.valid <= 1'b1;
        byte_if.byte_in <= rx_bytes[0].b;
      end else begin
        byte_if.valid <= 1'b0;
        byte_if.byte_in <= 8'($urandom);
      end
    end
  end

  initial begin : msg_sink
    int hold;
    hold = 0;
    msg_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        msg_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (hold > 0) begin
        msg_if.ready <= 1'b0;
        hold--;
      end else begin
        msg_if.ready <= 1'b1;
        if (!steady) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : msg_check
    msg_word_t got_w;
    msg_word_t exp_w;
    if (!rst && msg_if.valid && msg_if.ready) begin
      got_w.kind = msg_if.kind;
      got_w.body_byte = msg_if.body_byte;
      got_w.end_of_message = msg_if.end_of_message;
      got_w.msg_time = msg_if.msg_time;
      got_w.msg_type = msg_if.msg_type;
      got_w.msg_size = msg_if.msg_size;
      if (due_msg_words.size() == 0) begin
        flag_error($sformatf("unexpected word kind=%0d byte=%02h", got_w.kind,
                             got_w.body_byte));
      end else begin
        exp_w = due_msg_words.pop_front();
        if (got_w.kind !== exp_w.kind || got_w.body_byte !== exp_w.body_byte ||
            got_w.end_of_message !== exp_w.end_of_message ||
            got_w.msg_time !== exp_w.msg_time || got_w.msg_type !== exp_w.msg_type ||
            got_w.msg_size !== exp_w.msg_size)
          flag_error($sformatf({"word mismatch exp %0d/%02h/%0b/%h/%h/%0d",
                                " got %0d/%02h/%0b/%h/%h/%0d"},
                               exp_w.kind, exp_w.body_byte, exp_w.end_of_message,
                               exp_w.msg_time, exp_w.msg_type, exp_w.msg_size,
                               got_w.kind, got_w.body_byte, got_w.end_of_message,
                               got_w.msg_time, got_w.msg_type, got_w.msg_size));
      end
    end
  end

  initial begin : main_seq
    frame_row_t rows[$];
    logic [31:0] magic;
    bit hdr_open;
    int phase_start;
    hdr_open = 1'b0;
    rst <= 1'b1;
    cfg_if.valid <= 1'b0;
    cfg_if.expected_magic <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    //                    cfg   cfg value     magic rest magic
    //                    time                  type          length        check
    rows.push_back(mk_row(1'b0, 32'h0,        1'b1, 1'b0, 32'hFFFF_FFFF,
                          64'h0,                32'h0,        32'h0,        CHK_BAD_MAGIC));
    rows.push_back(mk_row(1'b0, 32'h0,        1'b1, 1'b1, 32'h0,
                          64'h8000_0000_0000_0000, 32'h7FFF_FFFF, 32'h0,     CHK_EMPTY));
    rows.push_back(mk_row(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF,
                          64'h7FFF_FFFF_FFFF_FFFF, 32'h8000_0000, 32'h8000_0000, CHK_EMPTY));
    rows.push_back(mk_row(1'b0, 32'h0,        1'b1, 1'b1, 32'hFFFF_FFFF,
                          64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h1,     CHK_MODEL));
    rows.push_back(mk_row(1'b0, 32'h0,        1'b1, 1'b1, 32'hFFFF_FFFF,
                          64'h0,                32'h0,        32'h3,        CHK_MODEL));
    rows.push_back(mk_row(1'b0, 32'h0,        1'b1, 1'b0, 32'h0,
                          64'h0,                32'h0,        32'h0,        CHK_BAD_MAGIC));
    // good magic only: header left open across the register write below
    rows.push_back(mk_row(1'b0, 32'h0,        1'b1, 1'b0, 32'hFFFF_FFFF,
                          64'h0,                32'h0,        32'h0,        CHK_MODEL));
    rows.push_back(mk_row(1'b1, 32'h5A5A_A5A5, 1'b0, 1'b1, 32'h0,
                          64'h0123_4567_89AB_CDEF, 32'h3C3C_C3C3, 32'h2,     CHK_MODEL));
    rows.push_back(mk_row(1'b0, 32'h0,        1'b1, 1'b0, 32'hFFFF_FFFF,
                          64'h0,                32'h0,        32'h0,        CHK_BAD_MAGIC));
    rows.push_back(mk_row(1'b0, 32'h0,        1'b1, 1'b1, 32'h5A5A_A5A5,
                          64'hFEDC_BA98_7654_3210, 32'h1234_5678, 32'hFFFF_FFFF, CHK_EMPTY));

    foreach (rows[i]) begin
      if (rows[i].set_cfg) begin
        wait_idle();
        write_magic(rows[i].cfg_val);
      end
      queue_frame(rows[i]);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      steady = (p % 4 == 3);
      case (p % 4)
        1: magic = 32'h0;
        2: magic = 32'hFFFF_FFFF;
        default: magic = $urandom;
      endcase
      write_magic(magic);
      phase_start = bytes_made;
      if (hdr_open) begin
        queue_frame(mk_row(1'b0, '0, 1'b0, 1'b1, magic, {$urandom, $urandom}, $urandom,
                           32'($urandom_range(1, 16)), CHK_MODEL));
        hdr_open = 1'b0;
      end
      while (bytes_made - phase_start < PHASE_BYTES) queue_frame(random_row(magic));
      if ($urandom_range(1)) begin
        queue_frame(mk_row(1'b0, '0, 1'b1, 1'b0, magic, '0, '0, '0, CHK_MODEL));
        hdr_open = 1'b1;
      end
      // stall the output long enough to back up the byte input
      if (p == 1) long_hold_req = 1'b1;
    end

    while (rx_bytes.size() != 0 || byte_if.valid) @(posedge clk);
    for (int n = 0; n < 1000 && due_msg_words.size() != 0; n++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (due_msg_words.size() != 0)
      flag_error($sformatf("%0d expected words never arrived", due_msg_words.size()));
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
